FILE: hw/rtl/ffha_pkg.sv
// Package for the first-fit heap allocator: request/response beat types,
// extent table entry type, status codes and table sizing. No dependencies.
`timescale 1ns / 1ps
package ffha_pkg;

  localparam int MAX_EXTENTS = 64;
  localparam int IDX_W       = $clog2(MAX_EXTENTS);
  localparam int CNT_W       = IDX_W + 1;

  localparam logic [47:0] HEAP_BASE_RST  = 48'h0000_1000_0000;
  localparam logic [32:0] HEAP_BYTES_RST = 33'd1048576;
  localparam logic [32:0] HEAP_MAX       = 33'h1_0000_0000;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO_SIZE = 3'd1;
  localparam logic [2:0] ST_NO_FIT    = 3'd2;
  localparam logic [2:0] ST_RANGE     = 3'd3;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd4;
  localparam logic [2:0] ST_MISALIGN  = 3'd5;
  localparam logic [2:0] ST_FULL      = 3'd6;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] REG_HEAP_BASE  = 2'd0;
  localparam logic [1:0] REG_HEAP_BYTES = 2'd1;

  typedef struct packed {
    logic        kind;
    logic [31:0] request_size;
    logic [47:0] free_address;
    logic [32:0] free_block_size;
  } ffha_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] user_address;
    logic [32:0] blk_size;
  } ffha_out_t;

  typedef struct packed {
    logic [31:0] off;
    logic [32:0] len;
  } ffha_ent_t;

endpackage

FILE: hw/rtl/first_fit_heap_allocator_unit.sv
// First-fit heap allocator with an address-ordered free extent table and
// coalescing. Depends on ffha_pkg.
`timescale 1ns / 1ps
//
// Channel   Direction  Signals                          Beat taken when
// request   in         start, busy, req                 start && !busy
// result    out        done, rsp                        done (one cycle)
// config    in         cfg_valid, cfg_ready, cfg_index, cfg_valid && cfg_ready
//                      cfg_data
//
// busy from the accepted beat up to the cycle before the result. Allocate walks the
// entries in order, reading and checking each, and moves later entries up on a
// whole-extent take. Free is refused by the checks or walks the entries to the
// insertion point, then merges, or moves entries on an insert or a double merge.
// Reset and a heap_bytes write hold busy while the table is rebuilt. The
// receiver cannot stall.
module first_fit_heap_allocator_unit
  import ffha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  ffha_in_t    req,
  output logic        done,
  output ffha_out_t   rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  // sequencer codes
  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_FLEN = 4'd3;
  localparam logic [3:0] S_ARD  = 4'd4;
  localparam logic [3:0] S_AEV  = 4'd5;
  localparam logic [3:0] S_RRD  = 4'd6;
  localparam logic [3:0] S_RWR  = 4'd7;
  localparam logic [3:0] S_FRD  = 4'd8;
  localparam logic [3:0] S_FEV  = 4'd9;
  localparam logic [3:0] S_FDEC = 4'd10;
  localparam logic [3:0] S_IRD  = 4'd11;
  localparam logic [3:0] S_IWR  = 4'd12;

  logic [3:0]       state;
  logic [47:0]      heap_base;
  logic [32:0]      heap_bytes;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] k;
  ffha_in_t         rq;
  logic [33:0]      total;
  logic [31:0]      foff;
  logic [32:0]      flen;
  ffha_ent_t        prev;
  ffha_ent_t        cur;
  logic             have_cur;

  // extent table RAM: one write and one registered read per cycle
  ffha_ent_t        mem [MAX_EXTENTS];
  ffha_ent_t        rdata;
  logic             mw_en;
  logic [IDX_W-1:0] mw_addr;
  ffha_ent_t        mw_data;
  logic [IDX_W-1:0] mr_addr;

  // shared arithmetic on the request, the heap bounds and the entries read
  logic [34:0] need_split;
  logic        fits;
  logic        splits;
  logic [33:0] f_end;
  logic [33:0] p_end;
  logic        mnext;
  logic        mprev;
  logic [32:0] rounded;
  logic [48:0] heap_end;
  logic [32:0] room;

  assign busy      = (state != S_IDLE);
  // a request beat takes precedence over a register write
  assign cfg_ready = (state == S_IDLE) && !start;

  assign rounded    = ({1'b0, rq.request_size} + 33'd15) & ~33'd15;
  assign heap_end   = {1'b0, heap_base} + {16'd0, heap_bytes};
  assign room       = heap_bytes - {1'b0, foff};
  assign fits       = ({1'b0, rdata.len} >= total);
  assign need_split = {1'b0, total} + 35'd16;
  assign splits     = ({2'b0, rdata.len} >= need_split);
  assign f_end      = {2'b0, foff} + {1'b0, flen};
  assign p_end      = {2'b0, prev.off} + {1'b0, prev.len};
  assign mnext      = have_cur && (f_end == {2'b0, cur.off});
  assign mprev      = (idx != '0) && (p_end == {2'b0, foff});

  always_comb begin
    mw_en   = 1'b0;
    mw_addr = '0;
    mw_data = '0;
    mr_addr = idx[IDX_W-1:0];
    unique case (state)
      S_INIT: begin
        mw_en   = 1'b1;
        mw_data = '{off: 32'd0, len: heap_bytes};
      end
      S_AEV: begin
        mw_addr = idx[IDX_W-1:0];
        mw_en   = fits && splits;
        mw_data = '{off: rdata.off + total[31:0], len: rdata.len - total[32:0]};
      end
      S_RRD: mr_addr = IDX_W'(k + 1'b1);
      S_RWR: begin
        mw_en   = 1'b1;
        mw_addr = k[IDX_W-1:0];
        mw_data = rdata;
      end
      S_FDEC: begin
        if (mprev) begin
          mw_en   = 1'b1;
          mw_addr = IDX_W'(idx - 1'b1);
          mw_data = '{off: prev.off,
                      len: prev.len + flen + (mnext ? cur.len : 33'd0)};
        end else if (mnext) begin
          mw_en   = 1'b1;
          mw_addr = idx[IDX_W-1:0];
          mw_data = '{off: foff, len: cur.len + flen};
        end
      end
      S_IRD: begin
        mr_addr = IDX_W'(k - 1'b1);
        if (k <= idx) begin
          mw_en   = 1'b1;
          mw_addr = idx[IDX_W-1:0];
          mw_data = '{off: foff, len: flen};
        end
      end
      S_IWR: begin
        mw_en   = 1'b1;
        mw_addr = k[IDX_W-1:0];
        mw_data = rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mw_en) begin
      mem[mw_addr] <= mw_data;
    end
    rdata <= mem[mr_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      heap_base  <= HEAP_BASE_RST;
      heap_bytes <= HEAP_BYTES_RST;
      cnt        <= CNT_W'(1);
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_INIT: begin
          cnt   <= CNT_W'(1);
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            rq    <= req;
            rsp   <= '0;
            state <= S_CHK;
          end else if (cfg_valid) begin
            if (cfg_index == REG_HEAP_BASE) begin
              heap_base <= cfg_data;
            end else if (cfg_index == REG_HEAP_BYTES) begin
              // saturate and rebuild the table
              heap_bytes <= (cfg_data[32:0] > HEAP_MAX) ? HEAP_MAX : cfg_data[32:0];
              state      <= S_INIT;
            end
          end
        end
        S_CHK: begin
          idx      <= '0;
          have_cur <= 1'b0;
          if (rq.kind == KIND_ALLOC) begin
            total <= {1'b0, rounded} + 34'd16;
            if (rq.request_size == 32'd0) begin
              rsp.status <= ST_ZERO_SIZE;
              done       <= 1'b1;
              state      <= S_IDLE;
            end else begin
              state <= S_ARD;
            end
          end else begin
            foff   <= 32'(rq.free_address - 48'd16 - heap_base);
            // range first, then size, then alignment
            if (rq.free_address < 48'd16 ||
                (rq.free_address - 48'd16) < heap_base ||
                {1'b0, rq.free_address - 48'd16} >= heap_end) begin
              rsp.status <= ST_RANGE;
              done       <= 1'b1;
              state      <= S_IDLE;
            end else if (rq.free_block_size < 33'd16) begin
              rsp.status <= ST_BAD_SIZE;
              done       <= 1'b1;
              state      <= S_IDLE;
            end else if (rq.free_address[3:0] != 4'd0) begin
              rsp.status <= ST_MISALIGN;
              done       <= 1'b1;
              state      <= S_IDLE;
            end else begin
              state <= S_FLEN;
            end
          end
        end
        S_FLEN: begin
          // clamp the block to the heap end
          flen  <= (rq.free_block_size > room) ? room : rq.free_block_size;
          state <= S_FRD;
        end
        S_ARD: begin
          if (idx == cnt) begin
            rsp.status <= ST_NO_FIT;
            done       <= 1'b1;
            state      <= S_IDLE;
          end else begin
            state <= S_AEV;
          end
        end
        S_AEV: begin
          if (fits) begin
            rsp.status       <= ST_OK;
            rsp.user_address <= heap_base + {16'd0, rdata.off} + 48'd16;
            if (splits) begin
              rsp.blk_size <= total[32:0];
              done         <= 1'b1;
              state        <= S_IDLE;
            end else begin
              // take the whole extent and close the gap
              rsp.blk_size <= rdata.len;
              k            <= idx;
              state        <= S_RRD;
            end
          end else begin
            idx   <= idx + 1'b1;
            state <= S_ARD;
          end
        end
        S_RRD: begin
          if (k + 1'b1 < cnt) begin
            state <= S_RWR;
          end else begin
            cnt   <= cnt - 1'b1;
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_RWR: begin
          k     <= k + 1'b1;
          state <= S_RRD;
        end
        S_FRD: begin
          state <= (idx == cnt) ? S_FDEC : S_FEV;
        end
        S_FEV: begin
          if (rdata.off >= foff) begin
            cur      <= rdata;
            have_cur <= 1'b1;
            state    <= S_FDEC;
          end else begin
            prev  <= rdata;
            idx   <= idx + 1'b1;
            state <= S_FRD;
          end
        end
        S_FDEC: begin
          if (mprev && mnext) begin
            // previous absorbs both; drop the next entry
            rsp.status <= ST_OK;
            k          <= idx;
            state      <= S_RRD;
          end else if (mprev || mnext) begin
            rsp.status <= ST_OK;
            done       <= 1'b1;
            state      <= S_IDLE;
          end else if (cnt >= CNT_W'(MAX_EXTENTS)) begin
            rsp.status <= ST_FULL;
            done       <= 1'b1;
            state      <= S_IDLE;
          end else begin
            rsp.status <= ST_OK;
            k          <= cnt;
            state      <= S_IRD;
          end
        end
        S_IRD: begin
          if (k > idx) begin
            state <= S_IWR;
          end else begin
            cnt   <= cnt + 1'b1;
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_IWR: begin
          k     <= k - 1'b1;
          state <= S_IRD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_EXTENTS)) else $error("extent count past table depth");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result shown while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result repeated");
  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_IWR) |-> (cnt < CNT_W'(MAX_EXTENTS))) else $error("insert into full table");
`endif

endmodule

FILE: tb/sv/tb_first_fit_heap_allocator_unit.sv
// Self-checking bench for the first-fit heap allocator: directed corners, a
// fragmentation pass up to a full extent table and random traffic across
// several heap settings. Depends on ffha_pkg and first_fit_heap_allocator_unit.
`timescale 1ns / 1ps
module tb_first_fit_heap_allocator_unit;
  import ffha_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE      = 4 * MAX_EXTENTS + 40;

  typedef struct {
    logic [47:0] addr;
    logic [32:0] bsz;
  } live_blk_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  ffha_in_t  req = '0;
  logic      done;
  ffha_out_t rsp;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_HEAP_BASE;
  logic [47:0] cfg_data = '0;

  // Shadow copy of the allocator state, advanced at each accepted beat.
  logic [47:0] sh_base;
  logic [32:0] sh_bytes;
  logic [31:0] sh_off [MAX_EXTENTS];
  logic [32:0] sh_len [MAX_EXTENTS];
  int          sh_cnt;

  ffha_in_t    req_q[$];     // requests not yet presented
  ffha_out_t   grant_q[$];   // outcomes awaiting their result beat
  live_blk_t   live_q[$];    // blocks handed out and not yet freed
  int          errors = 0;
  int          cycles = 0;
  int          sent = 0;
  int          n_full = 0;
  int          n_merge = 0;
  bit          calm = 1'b0;

  first_fit_heap_allocator_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic void shadow_init();
    for (int k = 0; k < MAX_EXTENTS; k++) begin
      sh_off[k] = '0;
      sh_len[k] = '0;
    end
    sh_len[0] = sh_bytes;
    sh_cnt = 1;
  endfunction

  function automatic void shadow_drop(int i);
    for (int k = i; k + 1 < sh_cnt; k++) begin
      sh_off[k] = sh_off[k + 1];
      sh_len[k] = sh_len[k + 1];
    end
    sh_cnt--;
    sh_off[sh_cnt] = '0;
    sh_len[sh_cnt] = '0;
  endfunction

  // Work out the outcome of one request and update the shadow table.
  function automatic ffha_out_t alloc_outcome(ffha_in_t r);
    ffha_out_t o;
    logic [63:0] total, base_off, off, len, addr, tail;
    int i;
    bit mprev, mnext;
    o = '0;
    if (r.kind == KIND_ALLOC) begin
      if (r.request_size == 0) begin
        o.status = ST_ZERO_SIZE;
        return o;
      end
      total = ((64'(r.request_size) + 64'd15) & ~64'hF) + 64'd16;
      for (i = 0; i < sh_cnt; i++) begin
        if (64'(sh_len[i]) >= total) begin
          base_off = 64'(sh_off[i]);
          if (64'(sh_len[i]) >= total + 64'd16) begin
            sh_off[i] = 32'(base_off + total);
            sh_len[i] = 33'(64'(sh_len[i]) - total);
            o.blk_size = 33'(total);
          end else begin
            o.blk_size = sh_len[i];
            shadow_drop(i);
          end
          o.status = ST_OK;
          o.user_address = 48'(64'(sh_base) + base_off + 64'd16);
          return o;
        end
      end
      o.status = ST_NO_FIT;
      return o;
    end
    addr = 64'(r.free_address);
    if (addr < 64'd16) begin
      o.status = ST_RANGE;
      return o;
    end
    base_off = addr - 64'd16;
    if (base_off < 64'(sh_base) || base_off >= 64'(sh_base) + 64'(sh_bytes)) begin
      o.status = ST_RANGE;
      return o;
    end
    if (64'(r.free_block_size) < 64'd16) begin
      o.status = ST_BAD_SIZE;
      return o;
    end
    if (base_off[3:0] != 4'd0) begin
      o.status = ST_MISALIGN;
      return o;
    end
    off = base_off - 64'(sh_base);
    len = 64'(r.free_block_size);
    if (len > 64'(sh_bytes) - off) len = 64'(sh_bytes) - off;
    i = 0;
    while (i < sh_cnt && 64'(sh_off[i]) < off) i++;
    mnext = (i < sh_cnt) && (off + len == 64'(sh_off[i]));
    tail = (i > 0) ? 64'(sh_off[i - 1]) + 64'(sh_len[i - 1]) : 64'd0;
    mprev = (i > 0) && (tail == off);
    if (mprev && mnext) begin
      sh_len[i - 1] = 33'(64'(sh_len[i - 1]) + len + 64'(sh_len[i]));
      shadow_drop(i);
    end else if (mnext) begin
      sh_off[i] = 32'(off);
      sh_len[i] = 33'(64'(sh_len[i]) + len);
    end else if (mprev) begin
      sh_len[i - 1] = 33'(64'(sh_len[i - 1]) + len);
    end else begin
      if (sh_cnt >= MAX_EXTENTS) begin
        o.status = ST_FULL;
        return o;
      end
      for (int k = sh_cnt; k > i; k--) begin
        sh_off[k] = sh_off[k - 1];
        sh_len[k] = sh_len[k - 1];
      end
      sh_off[i] = 32'(off);
      sh_len[i] = 33'(len);
      sh_cnt++;
    end
    o.status = ST_OK;
    return o;
  endfunction

  // Driver: predict on each accepted beat, then present the next pending
  // request or drop start. Hold the current beat while busy.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        grant_q.push_back(alloc_outcome(req));
        sent++;
      end
      if (!start || !busy) begin
        if (req_q.size() > 0 && (calm || $urandom_range(99) >= 29)) begin
          start <= 1'b1;
          req   <= req_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done beat must match the oldest outcome.
  always @(posedge clk) begin
    ffha_out_t want;
    if (!rst && done) begin
      if (grant_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status=%0d addr=%h size=%h", $time,
                 rsp.status, rsp.user_address, rsp.blk_size);
      end else begin
        want = grant_q.pop_front();
        if (rsp.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, want.status, rsp.status);
        end
        if (rsp.user_address !== want.user_address) begin
          errors++;
          $display("%0t: user_address expected %h got %h", $time,
                   want.user_address, rsp.user_address);
        end
        if (rsp.blk_size !== want.blk_size) begin
          errors++;
          $display("%0t: blk_size expected %h got %h", $time,
                   want.blk_size, rsp.blk_size);
        end
        if (want.status == ST_FULL) n_full++;
        // Successful allocates carry a block size; keep them for later frees.
        if (want.status == ST_OK && want.blk_size != 0)
          live_q.push_back('{addr: want.user_address, bsz: want.blk_size});
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, grant_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_alloc(logic [31:0] sz);
    ffha_in_t r;
    r = '0;
    r.kind = KIND_ALLOC;
    r.request_size = sz;
    req_q.push_back(r);
  endtask

  task automatic push_free(logic [47:0] addr, logic [32:0] bsz);
    ffha_in_t r;
    r = '0;
    r.kind = KIND_FREE;
    r.free_address = addr;
    r.free_block_size = bsz;
    req_q.push_back(r);
  endtask

  // Wait until every request has been taken and answered.
  task automatic drain();
    while (req_q.size() > 0 || start || grant_q.size() > 0) @(posedge clk);
  endtask

  // Register write, only ever issued with the block drained.
  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    logic [32:0] v;
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_HEAP_BASE) begin
      sh_base = val;
    end else begin
      v = val[32:0];
      sh_bytes = (v > HEAP_MAX) ? HEAP_MAX : v;
      shadow_init();
      live_q.delete();
    end
  endtask

  // Random traffic: mostly legal allocate/free pairs, some garbage.
  task automatic random_batch(int n, int max_sz);
    int pick, j;
    ffha_in_t r;
    for (int b = 0; b < n; b++) begin
      pick = $urandom_range(99);
      if (pick < 45 && live_q.size() > 0) begin
        j = $urandom_range(live_q.size() - 1);
        push_free(live_q[j].addr, live_q[j].bsz);
        live_q.delete(j);
      end else if (pick < 88) begin
        push_alloc(($urandom_range(9) == 0) ? $urandom_range(max_sz * 8, 1)
                                           : $urandom_range(max_sz, 1));
      end else begin
        r.kind = 1'($urandom_range(1));
        r.request_size = $urandom;
        r.free_address = 48'({$urandom, $urandom});
        r.free_block_size = 33'({$urandom, $urandom});
        if ($urandom_range(1)) r.free_address = 48'(sh_base) + 48'($urandom_range(4096));
        req_q.push_back(r);
      end
      // Drain now and then so frees can use freshly granted blocks.
      if (b % 16 == 15) drain();
    end
    drain();
  endtask

  initial begin
    logic [47:0] b;
    sh_base  = HEAP_BASE_RST;
    sh_bytes = HEAP_BYTES_RST;
    shadow_init();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed corners on the reset heap.
    b = HEAP_BASE_RST;
    push_alloc(32'd0);                       // zero size
    push_alloc(32'd1);
    push_alloc(32'd16);
    push_alloc(32'd17);
    push_alloc(32'hFFFF_FFFF);               // no fit
    push_alloc(32'd1048560);                 // no fit now, fits an empty heap
    push_free(48'd0, 33'd32);                // below the header size
    push_free(48'd15, 33'd32);
    push_free(b, 33'd32);                    // block start below base
    push_free(b + 48'd16 + 48'd1048576, 33'd32); // past heap end
    push_free(b + 48'd16, 33'd15);           // bad size
    push_free(b + 48'd24, 33'd32);           // misaligned
    push_free(b + 48'd16 + 48'd1048560, 33'h1_FFFF_FFFF); // clamped at heap end
    drain();
    push_free(b + 48'd48, 33'd32);           // inserted; the next two merge, the last on both sides
    push_free(b + 48'd16, 33'd32);
    push_free(b + 48'd80, 33'd48);
    push_alloc(32'd1048544);                 // splits, leaving a 16-byte extent
    drain();
    live_q.delete();

    // Empty heap, then fill the extent table until it overflows.
    write_reg(REG_HEAP_BYTES, 48'd0);
    push_alloc(32'd1);
    push_free(b + 48'd16, 33'd32);
    write_reg(REG_HEAP_BYTES, 48'd8192);
    for (int k = 0; k < 140; k++) push_alloc(32'd16);
    drain();
    for (int k = 0; k < 140; k += 2) push_free(live_q[k].addr, live_q[k].bsz);
    drain();
    for (int k = 1; k < 140; k += 2) push_free(live_q[k].addr, live_q[k].bsz);
    drain();
    n_merge = sh_cnt;

    // Random traffic over several heap settings, extremes first.
    write_reg(REG_HEAP_BASE, 48'd0);
    write_reg(REG_HEAP_BYTES, 48'h1_0000_0000);
    random_batch(250, 4096);
    write_reg(REG_HEAP_BASE, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_HEAP_BYTES, 48'h1_FFFF_FFFF);   // saturates
    random_batch(150, 512);
    write_reg(REG_HEAP_BASE, 48'h8000_0000_0000);
    write_reg(REG_HEAP_BYTES, 48'd4096);
    calm = 1'b1;                                 // no gaps on this stretch
    random_batch(300, 96);
    calm = 1'b0;
    write_reg(REG_HEAP_BASE, 48'h0000_1000_0000);
    write_reg(REG_HEAP_BYTES, 48'd2048);
    random_batch(350, 48);
    while (sent < 1950) begin
      write_reg(REG_HEAP_BASE, 48'({$urandom, $urandom}));
      write_reg(REG_HEAP_BYTES, 48'({$urandom, $urandom}) & 48'h0000_0000_FFFF);
      random_batch(250, 256);
    end
    write_reg(REG_HEAP_BYTES, 48'({$urandom, $urandom}));
    push_alloc(32'd64);

    drain();
    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d requests over several heap settings, %0d table-full refusals,",
             sent, n_full);
    $display("extents left after fragment and refill pass: %0d", n_merge);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
